### src/mrwrf_pkg.sv
// Shared types and constants for the multi-read weak region finder.
`default_nettype none

package mrwrf_pkg;

    localparam int NUM_READS       = 8;
    localparam int MAX_TRACK_BYTES = 65536;
    localparam int BITS_PER_BYTE_W = 3;
    localparam int RUN_W           = 17;
    localparam int POS_W           = 17;
    localparam int OFFSET_W        = 16;
    localparam int BITS_W          = RUN_W + BITS_PER_BYTE_W;
    localparam int COUNT_W         = 13;
    localparam int USED_W          = 4;
    localparam int CFG_DATA_W      = 13;
    localparam int CFG_INDEX_W     = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_READS_IN_USE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_LIMIT = 1'b1;

    localparam logic [USED_W-1:0]  READS_IN_USE_RESET = 4'd2;
    localparam logic [COUNT_W-1:0] REGION_LIMIT_RESET = 13'd64;

    typedef logic [7:0] byte_t;
    typedef byte_t [NUM_READS-1:0] reads_t;

    // Per-position summary of the compared reads
    typedef struct packed {
        logic  differs;
        byte_t lo;
        byte_t hi;
    } cmp_t;

    // One result transaction
    typedef struct packed {
        logic                region_valid;
        logic [OFFSET_W-1:0] region_offset;
        logic [BITS_W-1:0]   region_bits;
        byte_t               lowest_byte;
        byte_t               highest_byte;
        logic [COUNT_W-1:0]  regions_found;
        logic                track_done;
    } res_t;

endpackage

`default_nettype wire

### src/mrwrf_compare.sv
// Compares the used reads of one position against read zero and finds min and max.
`default_nettype none

module mrwrf_compare (
    input  wire mrwrf_pkg::reads_t              reads,
    input  wire [mrwrf_pkg::USED_W-1:0]         reads_in_use,
    output mrwrf_pkg::cmp_t                     summary
);

    always_comb
    begin
        mrwrf_pkg::cmp_t acc;
        acc.differs = 1'b0;
        acc.lo      = reads[0];
        acc.hi      = reads[0];
        for (int r = 1; r < mrwrf_pkg::NUM_READS; r++)
        begin
            // read r counts only when it lies below reads_in_use
            if (mrwrf_pkg::USED_W'(r) < reads_in_use)
            begin
                if (reads[r] != reads[0])
                begin
                    acc.differs = 1'b1;
                end
                if (reads[r] < acc.lo)
                begin
                    acc.lo = reads[r];
                end
                if (reads[r] > acc.hi)
                begin
                    acc.hi = reads[r];
                end
            end
        end
        summary = acc;
    end

endmodule

`default_nettype wire

### src/multi_read_weak_region_finder.sv
// A result is computed from the input register and held in the result register.
// Throughput: one position per cycle while the skid register is free; the result register plus
// a one-entry skid register keep the input flowing while a result waits on a stalled consumer.
// Reset (rst_n low, asynchronous): pipeline empty, track state cleared, reads_in_use = 2,
// region_limit = 64. No clearing pass; the block takes transactions right after reset.
`default_nettype none

module multi_read_weak_region_finder (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // configuration
    input  wire                                  cfg_write,
    input  wire [mrwrf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [mrwrf_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire [7:0]                            read_byte_0,
    input  wire [7:0]                            read_byte_1,
    input  wire [7:0]                            read_byte_2,
    input  wire [7:0]                            read_byte_3,
    input  wire [7:0]                            read_byte_4,
    input  wire [7:0]                            read_byte_5,
    input  wire [7:0]                            read_byte_6,
    input  wire [7:0]                            read_byte_7,
    input  wire                                  end_of_track,
    // output channel
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic                                 region_valid,
    output logic [mrwrf_pkg::OFFSET_W-1:0]       region_offset,
    output logic [mrwrf_pkg::BITS_W-1:0]         region_bits,
    output logic [7:0]                           lowest_byte,
    output logic [7:0]                           highest_byte,
    output logic [mrwrf_pkg::COUNT_W-1:0]        regions_found,
    output logic                                 track_done
);

    // configuration registers
    logic [mrwrf_pkg::USED_W-1:0]   reads_in_use_reg;
    logic [mrwrf_pkg::COUNT_W-1:0]  region_limit_reg;

    // input register
    logic                           s1_valid_reg;
    mrwrf_pkg::reads_t              s1_reads_reg;
    logic                           s1_eot_reg;

    // track state
    logic                           inside_reg;
    logic [mrwrf_pkg::OFFSET_W-1:0] start_reg;
    logic [mrwrf_pkg::RUN_W-1:0]    run_bytes_reg;
    logic [7:0]                     run_min_reg;
    logic [7:0]                     run_max_reg;
    logic [mrwrf_pkg::POS_W-1:0]    position_reg;
    logic [mrwrf_pkg::COUNT_W-1:0]  emitted_reg;

    logic                           inside_next;
    logic [mrwrf_pkg::OFFSET_W-1:0] start_next;
    logic [mrwrf_pkg::RUN_W-1:0]    run_bytes_next;
    logic [7:0]                     run_min_next;
    logic [7:0]                     run_max_next;
    logic [mrwrf_pkg::POS_W-1:0]    position_next;
    logic [mrwrf_pkg::COUNT_W-1:0]  emitted_next;

    // result and skid registers
    logic                           out_valid_reg;
    mrwrf_pkg::res_t                out_res_reg;
    logic                           skid_valid_reg;
    mrwrf_pkg::res_t                skid_res_reg;

    mrwrf_pkg::cmp_t                summary;
    mrwrf_pkg::res_t                res;
    logic                           fire;
    logic                           emit;
    logic                           out_take;
    logic                           in_take;
    logic                           finish;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reads_in_use_reg <= mrwrf_pkg::READS_IN_USE_RESET;
            region_limit_reg <= mrwrf_pkg::REGION_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mrwrf_pkg::CFG_READS_IN_USE:
                    reads_in_use_reg <= cfg_data[mrwrf_pkg::USED_W-1:0];
                mrwrf_pkg::CFG_REGION_LIMIT:
                    region_limit_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // the stage advances whenever the skid register is free
    assign fire     = s1_valid_reg && !skid_valid_reg;
    assign in_stall = s1_valid_reg && skid_valid_reg;
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_reads_reg <= {read_byte_7, read_byte_6, read_byte_5, read_byte_4,
                             read_byte_3, read_byte_2, read_byte_1, read_byte_0};
            s1_eot_reg   <= end_of_track;
        end
    end

    mrwrf_compare u_compare (
        .reads        (s1_reads_reg),
        .reads_in_use (reads_in_use_reg),
        .summary      (summary)
    );

    // region tracking for the position in the input register
    always_comb
    begin
        logic active;
        active         = emitted_reg < region_limit_reg;
        inside_next    = inside_reg;
        start_next     = start_reg;
        run_bytes_next = run_bytes_reg;
        run_min_next   = run_min_reg;
        run_max_next   = run_max_reg;
        position_next  = position_reg;
        emitted_next   = emitted_reg;
        finish         = 1'b0;

        if (active)
        begin
            if (summary.differs)
            begin
                if (!inside_reg)
                begin
                    inside_next    = 1'b1;
                    start_next     = position_reg[mrwrf_pkg::OFFSET_W-1:0];
                    run_bytes_next = mrwrf_pkg::RUN_W'(1);
                    run_min_next   = summary.lo;
                    run_max_next   = summary.hi;
                end
                else
                begin
                    if (run_bytes_reg < mrwrf_pkg::RUN_W'(mrwrf_pkg::MAX_TRACK_BYTES))
                    begin
                        run_bytes_next = run_bytes_reg + 1'b1;
                    end
                    if (summary.lo < run_min_reg)
                    begin
                        run_min_next = summary.lo;
                    end
                    if (summary.hi > run_max_reg)
                    begin
                        run_max_next = summary.hi;
                    end
                end
                finish = s1_eot_reg;
            end
            else
            begin
                finish = inside_reg;
            end
            if (finish)
            begin
                emitted_next = emitted_reg + 1'b1;
                inside_next  = 1'b0;
            end
            position_next = position_reg + 1'b1;
        end

        res.region_valid  = finish;
        res.region_offset = finish ? start_next : '0;
        res.region_bits   = finish ? {run_bytes_next, {mrwrf_pkg::BITS_PER_BYTE_W{1'b0}}} : '0;
        res.lowest_byte   = finish ? run_min_next : '0;
        res.highest_byte  = finish ? run_max_next : '0;
        res.regions_found = emitted_next;
        res.track_done    = s1_eot_reg;
    end

    assign emit = fire && (finish || s1_eot_reg);

    // track state; end of track starts a fresh track
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg    <= 1'b0;
            start_reg     <= '0;
            run_bytes_reg <= '0;
            run_min_reg   <= '0;
            run_max_reg   <= '0;
            position_reg  <= '0;
            emitted_reg   <= '0;
        end
        else if (fire)
        begin
            if (s1_eot_reg)
            begin
                inside_reg    <= 1'b0;
                start_reg     <= '0;
                run_bytes_reg <= '0;
                run_min_reg   <= '0;
                run_max_reg   <= '0;
                position_reg  <= '0;
                emitted_reg   <= '0;
            end
            else
            begin
                inside_reg    <= inside_next;
                start_reg     <= start_next;
                run_bytes_reg <= run_bytes_next;
                run_min_reg   <= run_min_next;
                run_max_reg   <= run_max_next;
                position_reg  <= position_next;
                emitted_reg   <= emitted_next;
            end
        end
    end

    // result register with skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (emit)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (emit)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_res_reg <= res;
            end
            else
            begin
                out_res_reg <= res;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign region_valid  = out_res_reg.region_valid;
    assign region_offset = out_res_reg.region_offset;
    assign region_bits   = out_res_reg.region_bits;
    assign lowest_byte   = out_res_reg.lowest_byte;
    assign highest_byte  = out_res_reg.highest_byte;
    assign regions_found = out_res_reg.regions_found;
    assign track_done    = out_res_reg.track_done;

`ifndef SYNTH
    // skid entry is only ever filled behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while result register empty");

    // a reported region is never empty and is always counted
    a_region_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.region_valid) |->
        (out_res_reg.region_bits != '0 && out_res_reg.regions_found != '0))
        else $error("reported region has zero length or zero count");

    // the last position of a track leaves a cleared track state
    a_track_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_eot_reg) |=> (position_reg == '0 && emitted_reg == '0 && !inside_reg))
        else $error("track state not cleared after end of track");

    // every processed end of track yields a result transaction
    a_eot_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_eot_reg) |=> out_valid_reg)
        else $error("end of track produced no result");
`endif

endmodule

`default_nettype wire

### verif/multi_read_weak_region_finder_test.sv
// Self-checking testbench for the multi-read weak region finder.
`timescale 1ns / 1ps

module multi_read_weak_region_finder_test;

    localparam int SETTLE_CYCLES = 8;
    localparam int RESULT_WAIT   = 400;

    typedef struct {
        mrwrf_pkg::reads_t rd;
        bit                eot;
    } track_pos_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              cfg_write = 1'b0;
    logic [mrwrf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mrwrf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] read_byte_0 = '0;
    logic [7:0] read_byte_1 = '0;
    logic [7:0] read_byte_2 = '0;
    logic [7:0] read_byte_3 = '0;
    logic [7:0] read_byte_4 = '0;
    logic [7:0] read_byte_5 = '0;
    logic [7:0] read_byte_6 = '0;
    logic [7:0] read_byte_7 = '0;
    logic       end_of_track = 1'b0;

    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic                           region_valid;
    logic [mrwrf_pkg::OFFSET_W-1:0] region_offset;
    logic [mrwrf_pkg::BITS_W-1:0]   region_bits;
    logic [7:0]                     lowest_byte;
    logic [7:0]                     highest_byte;
    logic [mrwrf_pkg::COUNT_W-1:0]  regions_found;
    logic                           track_done;

    // scanner state mirrored from the block
    logic [mrwrf_pkg::USED_W-1:0]   cmp_reads = mrwrf_pkg::READS_IN_USE_RESET;
    logic [mrwrf_pkg::COUNT_W-1:0]  region_cap = mrwrf_pkg::REGION_LIMIT_RESET;
    logic                           in_region = 1'b0;
    logic [mrwrf_pkg::OFFSET_W-1:0] region_start = '0;
    logic [mrwrf_pkg::RUN_W-1:0]    region_len = '0;
    mrwrf_pkg::byte_t               region_lo = '0;
    mrwrf_pkg::byte_t               region_hi = '0;
    logic [mrwrf_pkg::POS_W-1:0]    track_pos = '0;
    logic [mrwrf_pkg::COUNT_W-1:0]  regions_out = '0;

    track_pos_t      positions_to_send[$];
    mrwrf_pkg::res_t expected_reports[$];
    track_pos_t      on_bus;

    bit          send_gaps = 1'b1;
    bit          recv_stalls = 1'b1;
    int unsigned send_hold = 0;
    int unsigned stall_left = 0;

    int error_count = 0;
    int positions_accepted = 0;
    int reports_checked = 0;
    int regions_checked = 0;
    int tracks_queued = 0;
    int register_writes = 0;

    multi_read_weak_region_finder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .read_byte_0   (read_byte_0),
        .read_byte_1   (read_byte_1),
        .read_byte_2   (read_byte_2),
        .read_byte_3   (read_byte_3),
        .read_byte_4   (read_byte_4),
        .read_byte_5   (read_byte_5),
        .read_byte_6   (read_byte_6),
        .read_byte_7   (read_byte_7),
        .end_of_track  (end_of_track),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .region_valid  (region_valid),
        .region_offset (region_offset),
        .region_bits   (region_bits),
        .lowest_byte   (lowest_byte),
        .highest_byte  (highest_byte),
        .regions_found (regions_found),
        .track_done    (track_done)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Advance the scanner by one track position and queue the report it produces.
    function automatic void scan_position(input track_pos_t p);
        int               n_cmp;
        int               k;
        logic             differs;
        logic             finish;
        mrwrf_pkg::byte_t lo;
        mrwrf_pkg::byte_t hi;
        mrwrf_pkg::res_t  r;
        n_cmp = (cmp_reads > mrwrf_pkg::NUM_READS) ? mrwrf_pkg::NUM_READS : int'(cmp_reads);
        differs = 1'b0;
        finish = 1'b0;
        lo = p.rd[0];
        hi = p.rd[0];
        r = '0;
        for (k = 1; k < n_cmp; k++)
        begin
            if (p.rd[k] != p.rd[0])
                differs = 1'b1;
            if (p.rd[k] < lo)
                lo = p.rd[k];
            if (p.rd[k] > hi)
                hi = p.rd[k];
        end
        if (regions_out < region_cap)
        begin
            if (differs)
            begin
                if (!in_region)
                begin
                    in_region = 1'b1;
                    region_start = track_pos[mrwrf_pkg::OFFSET_W-1:0];
                    region_len = mrwrf_pkg::RUN_W'(1);
                    region_lo = lo;
                    region_hi = hi;
                end
                else
                begin
                    if (region_len < mrwrf_pkg::MAX_TRACK_BYTES)
                        region_len++;
                    if (lo < region_lo)
                        region_lo = lo;
                    if (hi > region_hi)
                        region_hi = hi;
                end
                finish = p.eot;
            end
            else
                finish = in_region;
            if (finish)
            begin
                r.region_valid = 1'b1;
                r.region_offset = region_start;
                r.region_bits = {region_len, 3'b000};
                r.lowest_byte = region_lo;
                r.highest_byte = region_hi;
                regions_out++;
                in_region = 1'b0;
            end
            track_pos++;
        end
        if (finish || p.eot)
        begin
            r.regions_found = regions_out;
            r.track_done = p.eot;
            expected_reports.push_back(r);
        end
        if (p.eot)
        begin
            in_region = 1'b0;
            region_start = '0;
            region_len = '0;
            region_lo = '0;
            region_hi = '0;
            track_pos = '0;
            regions_out = '0;
        end
    endfunction

    task automatic check_report;
        mrwrf_pkg::res_t want;
        if (expected_reports.size() == 0)
            flag_error($sformatf("result with nothing pending (offset %0d, count %0d)",
                                 region_offset, regions_found));
        else
        begin
            want = expected_reports.pop_front();
            reports_checked++;
            if (want.region_valid)
                regions_checked++;
            check_field("region_valid", region_valid, want.region_valid);
            check_field("region_offset", region_offset, want.region_offset);
            check_field("region_bits", region_bits, want.region_bits);
            check_field("lowest_byte", lowest_byte, want.lowest_byte);
            check_field("highest_byte", highest_byte, want.highest_byte);
            check_field("regions_found", regions_found, want.regions_found);
            check_field("track_done", track_done, want.track_done);
        end
    endtask

    // Input side: present queued positions, with random bursts of idle cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_hold <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                scan_position(on_bus);
                positions_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_hold != 0)
                begin
                    in_valid <= 1'b0;
                    send_hold <= send_hold - 1;
                end
                else if (send_gaps && $urandom_range(0, 5) == 0)
                begin
                    in_valid <= 1'b0;
                    send_hold <= $urandom_range(0, 3);
                end
                else if (positions_to_send.size() != 0)
                begin
                    on_bus = positions_to_send.pop_front();
                    read_byte_0 <= on_bus.rd[0];
                    read_byte_1 <= on_bus.rd[1];
                    read_byte_2 <= on_bus.rd[2];
                    read_byte_3 <= on_bus.rd[3];
                    read_byte_4 <= on_bus.rd[4];
                    read_byte_5 <= on_bus.rd[5];
                    read_byte_6 <= on_bus.rd[6];
                    read_byte_7 <= on_bus.rd[7];
                    end_of_track <= on_bus.eot;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output side: check each transaction and stall in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_report();
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (recv_stalls && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 3);
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic queue_position(input mrwrf_pkg::reads_t rd, input bit eot);
        track_pos_t p;
        p.rd = rd;
        p.eot = eot;
        positions_to_send.push_back(p);
        if (eot)
            tracks_queued++;
    endtask

    task automatic set_register(input logic [mrwrf_pkg::CFG_INDEX_W-1:0] idx,
                                input int unsigned value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= mrwrf_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == mrwrf_pkg::CFG_READS_IN_USE)
            cmp_reads = mrwrf_pkg::USED_W'(value);
        else
            region_cap = mrwrf_pkg::COUNT_W'(value);
        register_writes++;
    endtask

    // Hold until every position is taken and every report is back, then let the pipe settle.
    task automatic wait_drained;
        int spins;
        spins = 0;
        do
            @(negedge clk);
        while (positions_to_send.size() != 0 || in_valid);
        while (expected_reports.size() != 0 && spins < RESULT_WAIT)
        begin
            @(negedge clk);
            spins++;
        end
        if (expected_reports.size() != 0)
        begin
            flag_error($sformatf("%0d results never arrived", expected_reports.size()));
            expected_reports.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One track of random content: weak runs with random disagreeing reads, plus noise tracks.
    task automatic queue_track(input int len);
        int                n_cmp;
        int                i;
        int                k;
        int                idx;
        bit                noisy;
        bit                weak_run;
        mrwrf_pkg::byte_t  base;
        mrwrf_pkg::reads_t rd;
        n_cmp = (cmp_reads > mrwrf_pkg::NUM_READS) ? mrwrf_pkg::NUM_READS : int'(cmp_reads);
        noisy = ($urandom_range(0, 7) == 0);
        weak_run = 1'b0;
        for (i = 0; i < len; i++)
        begin
            base = mrwrf_pkg::byte_t'($urandom_range(0, 255));
            for (k = 0; k < mrwrf_pkg::NUM_READS; k++)
                rd[k] = noisy ? mrwrf_pkg::byte_t'($urandom_range(0, 255)) : base;
            weak_run = weak_run ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) < 3);
            if (!noisy && weak_run && n_cmp >= 2)
            begin
                idx = $urandom_range(1, n_cmp - 1);
                rd[idx] = base ^ mrwrf_pkg::byte_t'($urandom_range(1, 255));
                for (k = 1; k < mrwrf_pkg::NUM_READS; k++)
                    if ($urandom_range(0, 3) == 0)
                        rd[k] = mrwrf_pkg::byte_t'($urandom_range(0, 255));
            end
            else if (!noisy && $urandom_range(0, 2) == 0)
            begin
                // disagree only in reads that are not compared
                for (k = n_cmp; k < mrwrf_pkg::NUM_READS; k++)
                    rd[k] = mrwrf_pkg::byte_t'($urandom_range(0, 255));
            end
            queue_position(rd, i == len - 1);
        end
    endtask

    initial
    begin
        mrwrf_pkg::reads_t rd;
        int                ph;
        int                len;
        int                sent;
        bit                paused;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // stable, two weak extremes, stable with only unused reads off, weak at track end
        rd = {mrwrf_pkg::NUM_READS{8'h00}};
        queue_position(rd, 1'b0);
        rd[1] = 8'hFF;
        queue_position(rd, 1'b0);
        rd = {mrwrf_pkg::NUM_READS{8'hFF}};
        rd[1] = 8'h00;
        queue_position(rd, 1'b0);
        rd = {mrwrf_pkg::NUM_READS{8'hA5}};
        rd[0] = 8'h5A;
        rd[1] = 8'h5A;
        queue_position(rd, 1'b0);
        rd = {mrwrf_pkg::NUM_READS{8'h80}};
        rd[1] = 8'h81;
        queue_position(rd, 1'b1);
        // single-position track with no region
        rd = {mrwrf_pkg::NUM_READS{8'h33}};
        queue_position(rd, 1'b1);
        wait_drained();

        // all reads compared, limit of one region: the rest of the track is skipped
        set_register(mrwrf_pkg::CFG_READS_IN_USE, 8);
        set_register(mrwrf_pkg::CFG_REGION_LIMIT, 1);
        rd = {mrwrf_pkg::NUM_READS{8'h10}};
        rd[7] = 8'h11;
        queue_position(rd, 1'b0);
        rd[7] = 8'h10;
        queue_position(rd, 1'b0);
        rd = {mrwrf_pkg::NUM_READS{8'h00}};
        rd[3] = 8'hFF;
        queue_position(rd, 1'b0);
        rd[5] = 8'h01;
        queue_position(rd, 1'b1);
        wait_drained();

        // read count above the maximum, largest limit the field holds
        set_register(mrwrf_pkg::CFG_READS_IN_USE, 15);
        set_register(mrwrf_pkg::CFG_REGION_LIMIT, 8191);
        rd = {mrwrf_pkg::NUM_READS{8'h00}};
        rd[7] = 8'hFF;
        queue_position(rd, 1'b0);
        rd = {mrwrf_pkg::NUM_READS{8'hFF}};
        rd[0] = 8'h00;
        queue_position(rd, 1'b0);
        rd = {mrwrf_pkg::NUM_READS{8'hFF}};
        rd[6] = 8'hFE;
        queue_position(rd, 1'b1);
        wait_drained();

        // too few reads to compare
        set_register(mrwrf_pkg::CFG_READS_IN_USE, 1);
        set_register(mrwrf_pkg::CFG_REGION_LIMIT, 4096);
        rd = {mrwrf_pkg::NUM_READS{8'h00}};
        rd[1] = 8'hFF;
        queue_position(rd, 1'b0);
        rd[1] = 8'h7F;
        queue_position(rd, 1'b1);
        wait_drained();

        // no reads and a zero limit: nothing is scanned
        set_register(mrwrf_pkg::CFG_READS_IN_USE, 0);
        set_register(mrwrf_pkg::CFG_REGION_LIMIT, 0);
        rd = {mrwrf_pkg::NUM_READS{8'hAA}};
        rd[1] = 8'h55;
        queue_position(rd, 1'b0);
        queue_position(rd, 1'b1);
        wait_drained();

        for (ph = 0; ph < 8; ph++)
        begin
            send_gaps = (ph % 3 != 1) && (ph != 7);
            recv_stalls = (ph % 3 != 2) && (ph != 7);
            set_register(mrwrf_pkg::CFG_READS_IN_USE,
                         (ph % 4 == 3) ? $urandom_range(0, 15) : $urandom_range(2, 8));
            case ($urandom_range(0, 9))
                0:       set_register(mrwrf_pkg::CFG_REGION_LIMIT, 0);
                1, 2:    set_register(mrwrf_pkg::CFG_REGION_LIMIT, $urandom_range(4096, 8191));
                3, 4, 5: set_register(mrwrf_pkg::CFG_REGION_LIMIT, $urandom_range(1, 3));
                default: set_register(mrwrf_pkg::CFG_REGION_LIMIT, $urandom_range(4, 80));
            endcase
            sent = 0;
            paused = 1'b0;
            while (sent < 200)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 150)
                                                  : $urandom_range(1, 40);
                queue_track(len);
                sent += len;
                // pause the sender halfway until all reports are back
                if (!paused && sent >= 100)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
        end

        $display("Covered %0d positions in %0d tracks; %0d results checked, %0d with a region.",
                 positions_accepted, tracks_queued, reports_checked, regions_checked);
        $display("Register writes: %0d, with read counts from 0 to 15 and limits 0 to 8191.",
                 register_writes);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("Timeout with %0d results outstanding", expected_reports.size());
        $display("Verification failed");
        $finish;
    end

endmodule
